>>> sv/mfld_pkg.sv
// Shared types and constants for the mel filter bank / log / DCT block.
`timescale 1ns / 1ps
`default_nettype none
package mfld_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR,
    ST_ACC,
    ST_END,
    ST_LRD,
    ST_LLD,
    ST_LNORM,
    ST_LSQM,
    ST_LSQU,
    ST_LSCM,
    ST_LSCW,
    ST_DRD,
    ST_DMUL,
    ST_DACC,
    ST_DOUT
  } state_e;

  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [4:0]         NUM_COEFFS_RST = 5'd13;
  localparam logic [8:0]         COUNT_MAX      = 9'd511;
  localparam logic [32:0]        LOG10_2_Q32    = 33'd1292913987;
  localparam logic signed [63:0] LOG_MIN        = -64'sd8388608;
  localparam logic signed [63:0] LOG_MAX        = 64'sd8388607;
  localparam logic signed [63:0] C_MAX          = 64'sd2147483647;
  localparam logic signed [63:0] C_MIN          = -64'sd2147483648;
  localparam logic [63:0]        Q30_ONE        = 64'd1073741824;
  localparam logic [63:0]        HALF_PI_Q30    = 64'd1686629713;

endpackage
`default_nettype wire

>>> sv/mel_filterbank_log_dct.sv
// MFCC back end: filter bank accumulate, log10 and DCT-II on one shared multiplier.
// Weight write: a single weight RAM write. Sample: one filter per cycle through the
// weight and energy RAM ports, then a pipeline drain and an end check.
// Frame end adds per filter a log (6 normalize steps, then for a nonzero energy 16
// squarings on the multiplier) and per coefficient a multiply-accumulate per filter.
// Input stalls for the whole sequence; the output register holds one coefficient.
// Reset: control cleared, num_coeffs = 13, energies read zero; weights not cleared.
`timescale 1ns / 1ps
`default_nettype none
module mel_filterbank_log_dct #(
  parameter int NUM_FILTERS = 26,
  parameter int NUM_BINS    = 257
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [4:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               func_i,
  input  wire logic [4:0]         filter_index_i,
  input  wire logic [8:0]         bin_index_i,
  input  wire logic [15:0]        weight_i,
  input  wire logic [31:0]        sample_i,
  input  wire logic               last_sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [4:0]              coeff_index_o,
  output logic signed [31:0]      coefficient_o,
  output logic                    last_coeff_o
);

  import mfld_pkg::*;

  localparam int FW     = $clog2(NUM_FILTERS);
  localparam int IW     = FW + 1;
  localparam int AW     = $clog2(NUM_FILTERS * NUM_BINS);
  localparam int PHASES = 4 * NUM_FILTERS;
  localparam int PW     = $clog2(PHASES);

  typedef logic signed [31:0] cos_tab_t [PHASES];

  // elaboration-time cosine table, built with truncating Horner steps
  function automatic logic [63:0] poly_cos(input logic [63:0] x);
    logic [63:0] x2, t;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 56;
    t  = Q30_ONE - ((x2 * t) >> 30) / 30;
    t  = Q30_ONE - ((x2 * t) >> 30) / 12;
    t  = Q30_ONE - ((x2 * t) >> 30) / 2;
    return t;
  endfunction

  function automatic logic [63:0] poly_sin(input logic [63:0] x);
    logic [63:0] x2, t;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  function automatic logic signed [31:0] cos_turn(input logic [31:0] tt);
    logic [1:0]  q;
    logic [63:0] r, x, c, s;
    logic signed [63:0] v;
    q = tt[31:30];
    r = {34'd0, tt[29:0]};
    if (r <= (64'd1 << 29)) begin
      x = (r * HALF_PI_Q30) >> 30;
      c = poly_cos(x);
      s = poly_sin(x);
    end else begin
      x = (((64'd1 << 30) - r) * HALF_PI_Q30) >> 30;
      c = poly_sin(x);
      s = poly_cos(x);
    end
    case (q)
      2'd0:    v = $signed(c);
      2'd1:    v = -$signed(s);
      2'd2:    v = -$signed(c);
      default: v = $signed(s);
    endcase
    return v[31:0];
  endfunction

  function automatic cos_tab_t build_cos();
    cos_tab_t    tab;
    logic [63:0] tt;
    for (int i = 0; i < PHASES; i++) begin
      tt = (64'(i) << 32) / PHASES;
      tab[i] = cos_turn(tt[31:0]);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos();

  // registers
  state_e                    state_q, state_d;
  logic [4:0]                ncoef_q, ncoef_d;
  logic [8:0]                seen_q, seen_d;
  logic [NUM_FILTERS-1:0]    evalid_q, evalid_d;
  logic [4:0]                fidx_q, fidx_d;
  logic [8:0]                bin_q, bin_d;
  logic [15:0]               weight_q, weight_d;
  logic [31:0]               sample_q, sample_d;
  logic                      last_q, last_d;
  logic [IW-1:0]             issue_q, issue_d;
  logic [AW-1:0]             wbase_q, wbase_d;
  logic                      v1_q, v1_d, v2_q, v2_d;
  logic [FW-1:0]             f1_q, f1_d, f2_q, f2_d;
  logic [63:0]               e1_q, e1_d;
  logic [63:0]               prod_q, prod_d;
  logic [FW-1:0]             f_q, f_d;
  logic [63:0]               e_q, e_d;
  logic                      zero_q, zero_d;
  logic [2:0]                nstep_q, nstep_d;
  logic [5:0]                shacc_q, shacc_d;
  logic [31:0]               m_q, m_d;
  logic [3:0]                sqi_q, sqi_d;
  logic [22:0]               l_q, l_d;
  logic [4:0]                cnt_q, cnt_d;
  logic [4:0]                k_q, k_d;
  logic [FW-1:0]             n_q, n_d;
  logic [PW-1:0]             ph_q, ph_d, step_q, step_d;
  logic signed [31:0]        cos_q, cos_d;
  logic signed [63:0]        acc_q, acc_d;
  logic                      oval_q, oval_d;
  logic [4:0]                oidx_q, oidx_d;
  logic signed [31:0]        ocoef_q, ocoef_d;
  logic                      olast_q, olast_d;

  // memory ports
  logic            w_we;
  logic [AW-1:0]   w_waddr, w_raddr;
  logic [15:0]     w_rdata;
  logic            e_we;
  logic [FW-1:0]   e_waddr, e_raddr;
  logic [63:0]     e_wdata, e_rdata;
  logic            l_we;
  logic [FW-1:0]   l_waddr, l_raddr;
  logic [23:0]     l_wdata, l_rdata;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  logic               in_acc;
  logic [64:0]        esum;
  logic [6:0]         sh;
  logic [63:0]        e_n;
  logic [5:0]         shacc_n;
  logic [6:0]         ip;
  logic               rneg;
  logic [63:0]        rmag, rlog, racc;
  logic signed [63:0] rs_log, rs_acc;
  logic [PW:0]        phsum, stsum;
  logic [4:0]         cnt_c;

  mfld_ram #(.WIDTH(16), .DEPTH(NUM_FILTERS * NUM_BINS)) u_wram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (weight_q),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  mfld_ram #(.WIDTH(64), .DEPTH(NUM_FILTERS)) u_eram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  mfld_ram #(.WIDTH(24), .DEPTH(NUM_FILTERS)) u_lram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  always_comb begin
    case (state_q)
      ST_ACC: begin
        mul_a = {1'b0, sample_q};
        mul_b = {17'd0, w_rdata};
      end
      ST_LSQM: begin
        mul_a = {1'b0, m_q};
        mul_b = {1'b0, m_q};
      end
      ST_LSCM: begin
        mul_a = {{10{l_q[22]}}, l_q};
        mul_b = LOG10_2_Q32;
      end
      ST_DMUL: begin
        mul_a = {{9{l_rdata[23]}}, l_rdata};
        mul_b = {cos_q[31], cos_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign w_raddr = wbase_q;
  assign w_waddr = AW'(32'(fidx_q) * NUM_BINS + 32'(bin_q));
  assign in_acc  = (state_q == ST_ACC);
  assign e_raddr = in_acc ? issue_q[FW-1:0] : f_q;
  assign l_raddr = n_q;
  assign l_waddr = f_q;

  // log rounding: half away from zero, shift 32
  assign rneg   = prod_q[63];
  assign rmag   = rneg ? (~prod_q + 64'd1) : prod_q;
  assign rlog   = (rmag + (64'd1 << 31)) >> 32;
  assign rs_log = rneg ? -$signed(rlog) : $signed(rlog);

  // coefficient rounding, shift 30
  assign racc   = acc_q[63] ? (~acc_q + 64'd1) : acc_q;
  assign rs_acc = acc_q[63] ? -$signed((racc + (64'd1 << 29)) >> 30)
                            : $signed((racc + (64'd1 << 29)) >> 30);

  assign esum   = {1'b0, e1_q} + {1'b0, prod_q};
  assign sh     = 7'd32 >> nstep_q;
  assign phsum  = {1'b0, ph_q} + {1'b0, step_q};
  assign stsum  = {1'b0, step_q} + (PW+1)'(2);
  assign cnt_c  = (32'(ncoef_q) < NUM_FILTERS) ? ncoef_q : 5'(NUM_FILTERS);

  always_comb begin
    state_d  = state_q;
    ncoef_d  = cfg_we_i ? cfg_wdata_i : ncoef_q;
    seen_d   = seen_q;
    evalid_d = evalid_q;
    fidx_d   = fidx_q;
    bin_d    = bin_q;
    weight_d = weight_q;
    sample_d = sample_q;
    last_d   = last_q;
    issue_d  = issue_q;
    wbase_d  = wbase_q;
    v1_d     = 1'b0;
    v2_d     = 1'b0;
    f1_d     = f1_q;
    f2_d     = f2_q;
    e1_d     = e1_q;
    prod_d   = mul_p[63:0];
    f_d      = f_q;
    e_d      = e_q;
    zero_d   = zero_q;
    nstep_d  = nstep_q;
    shacc_d  = shacc_q;
    m_d      = m_q;
    sqi_d    = sqi_q;
    l_d      = l_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    n_d      = n_q;
    ph_d     = ph_q;
    step_d   = step_q;
    cos_d    = cos_q;
    acc_d    = acc_q;
    oval_d   = oval_q && out_stall_i;
    oidx_d   = oidx_q;
    ocoef_d  = ocoef_q;
    olast_d  = olast_q;
    w_we     = 1'b0;
    e_we     = 1'b0;
    e_waddr  = f2_q;
    e_wdata  = esum[64] ? '1 : esum[63:0];
    l_we     = 1'b0;
    l_wdata  = '0;
    e_n      = e_q;
    shacc_n  = shacc_q;
    ip       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          fidx_d   = filter_index_i;
          bin_d    = bin_index_i;
          weight_d = weight_i;
          sample_d = sample_i;
          last_d   = last_sample_i;
          if (func_i == FUNC_WEIGHT) begin
            state_d = ST_WR;
          end else begin
            seen_d  = (seen_q == COUNT_MAX) ? seen_q : seen_q + 9'd1;
            issue_d = '0;
            wbase_d = AW'(bin_index_i);
            state_d = (32'(bin_index_i) < NUM_BINS) ? ST_ACC : ST_END;
          end
        end
      end
      ST_WR: begin
        w_we    = (32'(fidx_q) < NUM_FILTERS) && (32'(bin_q) < NUM_BINS);
        state_d = ST_IDLE;
      end
      ST_ACC: begin
        // issue -> RAM read -> multiply -> saturating add and write back
        if (32'(issue_q) < NUM_FILTERS) begin
          issue_d = issue_q + IW'(1);
          wbase_d = wbase_q + AW'(NUM_BINS);
          v1_d    = 1'b1;
          f1_d    = issue_q[FW-1:0];
        end
        v2_d = v1_q;
        f2_d = f1_q;
        e1_d = evalid_q[f1_q] ? e_rdata : '0;
        if (v2_q) begin
          e_we           = 1'b1;
          evalid_d[f2_q] = 1'b1;
        end
        if (!(32'(issue_q) < NUM_FILTERS) && !v1_q && !v2_q) begin
          state_d = ST_END;
        end
      end
      ST_END: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (seen_q >= 9'd2 && cnt_c != '0) begin
          cnt_d   = cnt_c;
          f_d     = '0;
          state_d = ST_LRD;
        end else begin
          evalid_d = '0;
          seen_d   = '0;
          state_d  = ST_IDLE;
        end
      end
      ST_LRD: begin
        state_d = ST_LLD;
      end
      ST_LLD: begin
        e_d     = evalid_q[f_q] ? e_rdata : '0;
        zero_d  = !evalid_q[f_q] || (e_rdata == '0);
        nstep_d = '0;
        shacc_d = '0;
        state_d = ST_LNORM;
      end
      ST_LNORM: begin
        // leading-zero normalize: shift by 32,16,8,4,2,1
        if ((e_q >> (7'd64 - sh)) == '0) begin
          e_n     = e_q << sh;
          shacc_n = shacc_q + sh[5:0];
        end
        e_d     = e_n;
        shacc_d = shacc_n;
        nstep_d = nstep_q + 3'd1;
        if (nstep_q == 3'd5) begin
          ip      = 7'd32 - {1'b0, shacc_n};
          m_d     = e_n[63:32];
          l_d     = {ip, 16'd0};
          sqi_d   = 4'd15;
          state_d = zero_q ? ST_LSCW : ST_LSQM;
        end
      end
      ST_LSQM: begin
        state_d = ST_LSQU;
      end
      ST_LSQU: begin
        if (prod_q[63]) begin
          l_d = l_q | (23'd1 << sqi_q);
          m_d = prod_q[63:32];
        end else begin
          m_d = prod_q[62:31];
        end
        sqi_d   = sqi_q - 4'd1;
        state_d = (sqi_q == '0) ? ST_LSCM : ST_LSQM;
      end
      ST_LSCM: begin
        state_d = ST_LSCW;
      end
      ST_LSCW: begin
        l_we = 1'b1;
        if (zero_q || rs_log < LOG_MIN) begin
          l_wdata = LOG_MIN[23:0];
        end else if (rs_log > LOG_MAX) begin
          l_wdata = LOG_MAX[23:0];
        end else begin
          l_wdata = rs_log[23:0];
        end
        f_d = f_q + FW'(1);
        if (f_q == FW'(NUM_FILTERS - 1)) begin
          k_d     = '0;
          n_d     = '0;
          ph_d    = '0;
          step_d  = '0;
          acc_d   = '0;
          state_d = ST_DRD;
        end else begin
          state_d = ST_LRD;
        end
      end
      ST_DRD: begin
        cos_d   = COS_TAB[ph_q];
        state_d = ST_DMUL;
      end
      ST_DMUL: begin
        state_d = ST_DACC;
      end
      ST_DACC: begin
        acc_d   = acc_q + $signed(prod_q);
        n_d     = n_q + FW'(1);
        ph_d    = (32'(phsum) >= PHASES) ? PW'(32'(phsum) - PHASES) : phsum[PW-1:0];
        state_d = (n_q == FW'(NUM_FILTERS - 1)) ? ST_DOUT : ST_DRD;
      end
      ST_DOUT: begin
        if (!oval_q || !out_stall_i) begin
          oval_d = 1'b1;
          oidx_d = k_q;
          if (rs_acc > C_MAX) begin
            ocoef_d = C_MAX[31:0];
          end else if (rs_acc < C_MIN) begin
            ocoef_d = C_MIN[31:0];
          end else begin
            ocoef_d = rs_acc[31:0];
          end
          olast_d = (k_q == cnt_q - 5'd1);
          if (k_q == cnt_q - 5'd1) begin
            evalid_d = '0;
            seen_d   = '0;
            state_d  = ST_IDLE;
          end else begin
            k_d     = k_q + 5'd1;
            step_d  = (32'(stsum) >= PHASES) ? PW'(32'(stsum) - PHASES) : stsum[PW-1:0];
            ph_d    = PW'(k_q + 5'd1);
            n_d     = '0;
            acc_d   = '0;
            state_d = ST_DRD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ncoef_q  <= NUM_COEFFS_RST;
      seen_q   <= '0;
      evalid_q <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      oval_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ncoef_q  <= ncoef_d;
      seen_q   <= seen_d;
      evalid_q <= evalid_d;
      v1_q     <= v1_d;
      v2_q     <= v2_d;
      oval_q   <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fidx_q   <= fidx_d;
    bin_q    <= bin_d;
    weight_q <= weight_d;
    sample_q <= sample_d;
    last_q   <= last_d;
    issue_q  <= issue_d;
    wbase_q  <= wbase_d;
    f1_q     <= f1_d;
    f2_q     <= f2_d;
    e1_q     <= e1_d;
    prod_q   <= prod_d;
    f_q      <= f_d;
    e_q      <= e_d;
    zero_q   <= zero_d;
    nstep_q  <= nstep_d;
    shacc_q  <= shacc_d;
    m_q      <= m_d;
    sqi_q    <= sqi_d;
    l_q      <= l_d;
    cnt_q    <= cnt_d;
    k_q      <= k_d;
    n_q      <= n_d;
    ph_q     <= ph_d;
    step_q   <= step_d;
    cos_q    <= cos_d;
    acc_q    <= acc_d;
    oidx_q   <= oidx_d;
    ocoef_q  <= ocoef_d;
    olast_q  <= olast_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = oval_q;
  assign coeff_index_o = oidx_q;
  assign coefficient_o = ocoef_q;
  assign last_coeff_o  = olast_q;

  // accumulate pipeline is drained whenever the block takes a new beat
  a_acc_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !v1_q && !v2_q)
    else $error("accumulate pipeline busy while idle");

  // normalized mantissa squared always lands in [2^62, 2^64)
  a_sq_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LSQU |-> prod_q[63] || prod_q[62])
    else $error("log mantissa not normalized");

  // frame end clears energies and sample count
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DOUT && state_d == ST_IDLE) |=> evalid_q == '0 && seen_q == '0)
    else $error("frame state not cleared");

  // a coefficient marked last always closes the emission sequence
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(oval_q) && olast_q |-> state_q == ST_IDLE)
    else $error("last coefficient emitted mid-frame");

endmodule
`default_nettype wire

>>> sv/mfld_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module mfld_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire
